// ===== hw/rtl/rmed_pkg.sv =====
// Shared types and constants for the running median with insert and delete
package rmed_pkg;

   localparam int CAPACITY_DEFAULT    = 64;
   localparam int VALUE_WIDTH_DEFAULT = 32;
   localparam int DATA_W              = 32;
   localparam int CMD_W               = 2;
   localparam int STATUS_W            = 2;
   localparam int COUNT_OUT_W         = 7;
   localparam int RSP_DATA_W          = 40;

   localparam logic [CMD_W-1:0] CMD_ADD    = 2'd0;
   localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

   localparam logic [STATUS_W-1:0] ST_DONE   = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL   = 2'd1;
   localparam logic [STATUS_W-1:0] ST_ABSENT = 2'd2;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DISPATCH,
      S_ADD_CHK,
      S_ADD_CMP,
      S_REM_CHK,
      S_REM_CMP,
      S_MED_RD,
      S_FINISH
   } state_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_SET_FULL,
      OP_CLEAR,
      OP_ADD_RD,
      OP_ADD_SHIFT,
      OP_ADD_PUT,
      OP_REM_RD,
      OP_REM_STEP,
      OP_REM_END,
      OP_MED_RD,
      OP_OUT
   } op_type;

   typedef struct packed {
      logic [CMD_W-1:0] cmd;
      logic             full;
      logic             idx_zero;
      logic             idx_end;
      logic             shift;
      logic             out_free;
   } dp_status_type;

endpackage

// ===== hw/rtl/running_median_insert_delete.sv =====
// Top level: running lower median of a bounded multiset with add, remove and clear.
// One command at a time; the sorted memory is scanned one entry at a time,
// each entry through a check state and a compare state.
// After the result loads the controller returns to idle and accepts the next beat;
// the load waits while an earlier result is still held, not yet taken on rsp_tready.
// Sync reset empties the set and drops any pending result; memory needs no clearing.
module running_median_insert_delete #(
   parameter int CAPACITY    = rmed_pkg::CAPACITY_DEFAULT,
   parameter int VALUE_WIDTH = rmed_pkg::VALUE_WIDTH_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [rmed_pkg::DATA_W-1:0]        req_tdata,   // value
   input  logic [rmed_pkg::CMD_W-1:0]         req_tuser,   // cmd
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [rmed_pkg::RSP_DATA_W-1:0]    rsp_tdata,   // median, has_median, element_count
   output logic [rmed_pkg::STATUS_W-1:0]      rsp_tuser    // status
);

   rmed_pkg::op_type                 dp_op;
   rmed_pkg::dp_status_type          dp_status;
   logic [rmed_pkg::DATA_W-1:0]      median;
   logic                             has_median;
   logic [rmed_pkg::COUNT_OUT_W-1:0] element_count;

   rmed_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .dp_status  (dp_status),
      .dp_op      (dp_op)
   );

   rmed_dp #(
      .CAPACITY    (CAPACITY),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .dp_op          (dp_op),
      .dp_status      (dp_status),
      .req_cmd        (req_tuser),
      .req_value      (req_tdata),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_median     (median),
      .rsp_has_median (has_median),
      .rsp_count      (element_count),
      .rsp_status     (rsp_tuser)
   );

   assign rsp_tdata = {element_count, has_median, median};

endmodule

// ===== hw/rtl/rmed_ctrl.sv =====
// Controller state machine sequencing insert, delete and median read
module rmed_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  rmed_pkg::dp_status_type dp_status,
   output rmed_pkg::op_type       dp_op
);

   rmed_pkg::state_type state_ff;
   rmed_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rmed_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         rmed_pkg::S_IDLE: begin
            if (req_tvalid) state_in = rmed_pkg::S_DISPATCH;
         end
         rmed_pkg::S_DISPATCH: begin
            case (dp_status.cmd)
               rmed_pkg::CMD_ADD: begin
                  state_in = dp_status.full ? rmed_pkg::S_MED_RD : rmed_pkg::S_ADD_CHK;
               end
               rmed_pkg::CMD_REMOVE: state_in = rmed_pkg::S_REM_CHK;
               default:              state_in = rmed_pkg::S_MED_RD;
            endcase
         end
         rmed_pkg::S_ADD_CHK: begin
            state_in = dp_status.idx_zero ? rmed_pkg::S_MED_RD : rmed_pkg::S_ADD_CMP;
         end
         rmed_pkg::S_ADD_CMP: begin
            state_in = dp_status.shift ? rmed_pkg::S_ADD_CHK : rmed_pkg::S_MED_RD;
         end
         rmed_pkg::S_REM_CHK: begin
            state_in = dp_status.idx_end ? rmed_pkg::S_MED_RD : rmed_pkg::S_REM_CMP;
         end
         rmed_pkg::S_REM_CMP: state_in = rmed_pkg::S_REM_CHK;
         rmed_pkg::S_MED_RD:  state_in = rmed_pkg::S_FINISH;
         rmed_pkg::S_FINISH: begin
            if (dp_status.out_free) state_in = rmed_pkg::S_IDLE;
         end
         default: state_in = rmed_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      dp_op      = rmed_pkg::OP_NONE;
      req_tready = 1'b0;
      case (state_ff)
         rmed_pkg::S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) dp_op = rmed_pkg::OP_LOAD;
         end
         rmed_pkg::S_DISPATCH: begin
            case (dp_status.cmd)
               rmed_pkg::CMD_ADD: begin
                  if (dp_status.full) dp_op = rmed_pkg::OP_SET_FULL;
               end
               rmed_pkg::CMD_CLEAR: dp_op = rmed_pkg::OP_CLEAR;
               default:             dp_op = rmed_pkg::OP_NONE;
            endcase
         end
         rmed_pkg::S_ADD_CHK: begin
            dp_op = dp_status.idx_zero ? rmed_pkg::OP_ADD_PUT : rmed_pkg::OP_ADD_RD;
         end
         rmed_pkg::S_ADD_CMP: begin
            dp_op = dp_status.shift ? rmed_pkg::OP_ADD_SHIFT : rmed_pkg::OP_ADD_PUT;
         end
         rmed_pkg::S_REM_CHK: begin
            dp_op = dp_status.idx_end ? rmed_pkg::OP_REM_END : rmed_pkg::OP_REM_RD;
         end
         rmed_pkg::S_REM_CMP: dp_op = rmed_pkg::OP_REM_STEP;
         rmed_pkg::S_MED_RD:  dp_op = rmed_pkg::OP_MED_RD;
         rmed_pkg::S_FINISH: begin
            if (dp_status.out_free) dp_op = rmed_pkg::OP_OUT;
         end
         default: dp_op = rmed_pkg::OP_NONE;
      endcase
   end

endmodule

// ===== hw/rtl/rmed_dp.sv =====
// Datapath: sorted value memory, scan index, count and result register
module rmed_dp #(
   parameter int CAPACITY    = rmed_pkg::CAPACITY_DEFAULT,
   parameter int VALUE_WIDTH = rmed_pkg::VALUE_WIDTH_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  rmed_pkg::op_type                  dp_op,
   output rmed_pkg::dp_status_type           dp_status,
   input  logic [rmed_pkg::CMD_W-1:0]        req_cmd,
   input  logic [rmed_pkg::DATA_W-1:0]       req_value,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [rmed_pkg::DATA_W-1:0]       rsp_median,
   output logic                              rsp_has_median,
   output logic [rmed_pkg::COUNT_OUT_W-1:0]  rsp_count,
   output logic [rmed_pkg::STATUS_W-1:0]     rsp_status
);

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int XW = (CW > rmed_pkg::COUNT_OUT_W) ? CW : rmed_pkg::COUNT_OUT_W;
   localparam int EW = 64;

   logic [VALUE_WIDTH-1:0] mem [CAPACITY];

   logic [rmed_pkg::CMD_W-1:0]    cmd_ff;
   logic signed [VALUE_WIDTH-1:0] val_ff;
   logic signed [VALUE_WIDTH-1:0] rd_data_ff;
   logic [CW-1:0]                 count_ff;
   logic [CW-1:0]                 idx_ff;
   logic                          found_ff;
   logic [rmed_pkg::STATUS_W-1:0] status_ff;

   logic                              rsp_valid_ff;
   logic [rmed_pkg::DATA_W-1:0]       median_ff;
   logic                              has_ff;
   logic [rmed_pkg::COUNT_OUT_W-1:0]  cnt_out_ff;
   logic [rmed_pkg::STATUS_W-1:0]     st_out_ff;

   logic signed [EW-1:0]   req_ext;
   logic signed [EW-1:0]   med_ext;
   logic [CW-1:0]          idx_dec;
   logic [CW-1:0]          med_idx;
   logic [XW-1:0]          count_ext;
   logic                   wr_en;
   logic [AW-1:0]          wr_addr;
   logic [VALUE_WIDTH-1:0] wr_data;
   logic                   rd_en;
   logic [AW-1:0]          rd_addr;

   assign req_ext   = EW'(signed'(req_value));
   assign med_ext   = EW'(rd_data_ff);
   assign idx_dec   = idx_ff - CW'(1);
   assign med_idx   = (count_ff - CW'(1)) >> 1;
   assign count_ext = XW'(count_ff);

   assign dp_status.cmd      = cmd_ff;
   assign dp_status.full     = (count_ff == CW'(CAPACITY));
   assign dp_status.idx_zero = (idx_ff == '0);
   assign dp_status.idx_end  = (idx_ff == count_ff);
   assign dp_status.shift    = (rd_data_ff > val_ff);
   assign dp_status.out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = idx_ff[AW-1:0];
      wr_data = val_ff;
      rd_en   = 1'b0;
      rd_addr = idx_ff[AW-1:0];
      case (dp_op)
         rmed_pkg::OP_ADD_RD: begin
            rd_en   = 1'b1;
            rd_addr = idx_dec[AW-1:0];
         end
         rmed_pkg::OP_ADD_SHIFT: begin
            wr_en   = 1'b1;
            wr_data = rd_data_ff;
         end
         rmed_pkg::OP_ADD_PUT: wr_en = 1'b1;
         rmed_pkg::OP_REM_RD:  rd_en = 1'b1;
         rmed_pkg::OP_REM_STEP: begin
            wr_en   = found_ff;
            wr_addr = idx_dec[AW-1:0];
            wr_data = rd_data_ff;
         end
         rmed_pkg::OP_MED_RD: begin
            rd_en   = 1'b1;
            rd_addr = med_idx[AW-1:0];
         end
         default: wr_en = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      if (rd_en) rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         cmd_ff       <= rmed_pkg::CMD_ADD;
         idx_ff       <= '0;
         found_ff     <= 1'b0;
         status_ff    <= rmed_pkg::ST_DONE;
      end else begin
         if (dp_op == rmed_pkg::OP_OUT) rsp_valid_ff <= 1'b1;
         else if (rsp_tready)          rsp_valid_ff <= 1'b0;
         case (dp_op)
            rmed_pkg::OP_LOAD: begin
               cmd_ff    <= req_cmd;
               val_ff    <= req_ext[VALUE_WIDTH-1:0];
               status_ff <= rmed_pkg::ST_DONE;
               found_ff  <= 1'b0;
               idx_ff    <= (req_cmd == rmed_pkg::CMD_ADD) ? count_ff : '0;
            end
            rmed_pkg::OP_SET_FULL: status_ff <= rmed_pkg::ST_FULL;
            rmed_pkg::OP_CLEAR:    count_ff  <= '0;
            rmed_pkg::OP_ADD_SHIFT: idx_ff   <= idx_dec;
            rmed_pkg::OP_ADD_PUT:  count_ff  <= count_ff + CW'(1);
            rmed_pkg::OP_REM_STEP: begin
               if (!found_ff && rd_data_ff == val_ff) found_ff <= 1'b1;
               idx_ff <= idx_ff + CW'(1);
            end
            rmed_pkg::OP_REM_END: begin
               if (found_ff) count_ff  <= count_ff - CW'(1);
               else          status_ff <= rmed_pkg::ST_ABSENT;
            end
            rmed_pkg::OP_OUT: begin
               median_ff    <= (count_ff == '0) ? '0 : med_ext[rmed_pkg::DATA_W-1:0];
               has_ff       <= (count_ff != '0);
               cnt_out_ff   <= count_ext[rmed_pkg::COUNT_OUT_W-1:0];
               st_out_ff    <= status_ff;
            end
            default: found_ff <= found_ff;
         endcase
      end
   end

   assign rsp_tvalid     = rsp_valid_ff;
   assign rsp_median     = median_ff;
   assign rsp_has_median = has_ff;
   assign rsp_count      = cnt_out_ff;
   assign rsp_status     = st_out_ff;

endmodule

// ===== verif/tb.sv =====
// Testbench for running_median_insert_delete: directed table, then random add/remove/clear/unused-code traffic
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CAPACITY = rmed_pkg::CAPACITY_DEFAULT;
   localparam logic [rmed_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;
   localparam int RANDOM_ITEMS = 1125;
   localparam int PHASE_ITEMS = 160;
   localparam int DRAIN_EVERY = 250;
   localparam int TAIL_CYCLES = 2 * CAPACITY + 40;
   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int PRINT_LIMIT = 50;

   typedef struct packed {
      logic [rmed_pkg::DATA_W-1:0]      median;
      logic                             has_median;
      logic [rmed_pkg::COUNT_OUT_W-1:0] count;
      logic [rmed_pkg::STATUS_W-1:0]    status;
   } median_result_type;

   typedef struct {
      logic [rmed_pkg::CMD_W-1:0]       cmd;
      logic [rmed_pkg::DATA_W-1:0]      value;
      bit                               typed;
      logic [rmed_pkg::DATA_W-1:0]      median;
      logic                             has_median;
      logic [rmed_pkg::COUNT_OUT_W-1:0] count;
      logic [rmed_pkg::STATUS_W-1:0]    status;
   } command_row_type;

   logic                              clock;
   logic                              reset;
   logic                              req_tvalid;
   logic                              req_tready;
   logic [rmed_pkg::DATA_W-1:0]       req_tdata;    // value
   logic [rmed_pkg::CMD_W-1:0]        req_tuser;    // cmd
   logic                              rsp_tvalid;
   logic                              rsp_tready;
   logic [rmed_pkg::RSP_DATA_W-1:0]   rsp_tdata;    // median, has_median, element_count
   logic [rmed_pkg::STATUS_W-1:0]     rsp_tuser;    // status

   logic signed [rmed_pkg::DATA_W-1:0] held_values [CAPACITY];
   int                                 held_count;
   median_result_type                  pending_medians [$];
   int                                 mismatches = 0;
   int                                 cycle_count = 0;
   bit                                 quiet_sender;
   bit                                 quiet_receiver;

   command_row_type directed_rows [25] = '{
      '{rmed_pkg::CMD_REMOVE, 32'd5, 1'b1, 32'd0, 1'b0, 7'd0, rmed_pkg::ST_ABSENT},
      '{rmed_pkg::CMD_CLEAR, 32'd0, 1'b1, 32'd0, 1'b0, 7'd0, rmed_pkg::ST_DONE},
      '{CMD_UNUSED, 32'd0, 1'b1, 32'd0, 1'b0, 7'd0, rmed_pkg::ST_DONE},
      '{rmed_pkg::CMD_ADD, 32'h7FFF_FFFF, 1'b1, 32'h7FFF_FFFF, 1'b1, 7'd1, rmed_pkg::ST_DONE},
      '{rmed_pkg::CMD_ADD, 32'h8000_0000, 1'b1, 32'h8000_0000, 1'b1, 7'd2, rmed_pkg::ST_DONE},
      '{rmed_pkg::CMD_ADD, 32'd0, 1'b1, 32'd0, 1'b1, 7'd3, rmed_pkg::ST_DONE},
      '{rmed_pkg::CMD_REMOVE, 32'd1234, 1'b1, 32'd0, 1'b1, 7'd3, rmed_pkg::ST_ABSENT},
      '{rmed_pkg::CMD_ADD, 32'hFFFF_FFFF, 1'b0, 32'd0, 1'b0, 7'd0, rmed_pkg::ST_DONE},
      '{rmed_pkg::CMD_ADD, 32'hFFFF_FFFF, 1'b0, 32'd0, 1'b0, 7'd0, rmed_pkg::ST_DONE},
      '{rmed_pkg::CMD_ADD, 32'hFFFF_FFFF, 1'b0, 32'd0, 1'b0, 7'd0, rmed_pkg::ST_DONE},
      '{rmed_pkg::CMD_REMOVE, 32'hFFFF_FFFF, 1'b0, 32'd0, 1'b0, 7'd0, rmed_pkg::ST_DONE},
      '{CMD_UNUSED, 32'hFFFF_FFFF, 1'b0, 32'd0, 1'b0, 7'd0, rmed_pkg::ST_DONE},
      '{rmed_pkg::CMD_REMOVE, 32'h8000_0000, 1'b0, 32'd0, 1'b0, 7'd0, rmed_pkg::ST_DONE},
      '{rmed_pkg::CMD_REMOVE, 32'h7FFF_FFFF, 1'b0, 32'd0, 1'b0, 7'd0, rmed_pkg::ST_DONE},
      '{rmed_pkg::CMD_ADD, 32'h5555_5555, 1'b0, 32'd0, 1'b0, 7'd0, rmed_pkg::ST_DONE},
      '{rmed_pkg::CMD_ADD, 32'hAAAA_AAAA, 1'b0, 32'd0, 1'b0, 7'd0, rmed_pkg::ST_DONE},
      '{rmed_pkg::CMD_CLEAR, 32'hFFFF_FFFF, 1'b1, 32'd0, 1'b0, 7'd0, rmed_pkg::ST_DONE},
      '{rmed_pkg::CMD_REMOVE, 32'd0, 1'b1, 32'd0, 1'b0, 7'd0, rmed_pkg::ST_ABSENT},
      '{rmed_pkg::CMD_ADD, 32'd7, 1'b1, 32'd7, 1'b1, 7'd1, rmed_pkg::ST_DONE},
      '{rmed_pkg::CMD_REMOVE, 32'd7, 1'b1, 32'd0, 1'b0, 7'd0, rmed_pkg::ST_DONE},
      '{rmed_pkg::CMD_ADD, 32'd1, 1'b0, 32'd0, 1'b0, 7'd0, rmed_pkg::ST_DONE},
      '{rmed_pkg::CMD_ADD, 32'd1, 1'b0, 32'd0, 1'b0, 7'd0, rmed_pkg::ST_DONE},
      '{rmed_pkg::CMD_REMOVE, 32'd1, 1'b0, 32'd0, 1'b0, 7'd0, rmed_pkg::ST_DONE},
      '{rmed_pkg::CMD_REMOVE, 32'd1, 1'b0, 32'd0, 1'b0, 7'd0, rmed_pkg::ST_DONE},
      '{rmed_pkg::CMD_REMOVE, 32'd1, 1'b1, 32'd0, 1'b0, 7'd0, rmed_pkg::ST_ABSENT}
   };

   running_median_insert_delete uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial clock = 1'b0;
   always #10ns clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb: FAIL");
         $finish;
      end
   end

   function automatic median_result_type apply_command(logic [rmed_pkg::CMD_W-1:0] cmd,
                                                       logic signed [rmed_pkg::DATA_W-1:0] v);
      median_result_type r;
      int pos;
      r.status = rmed_pkg::ST_DONE;
      pos = 0;
      case (cmd)
         rmed_pkg::CMD_ADD: begin
            if (held_count >= CAPACITY) begin
               r.status = rmed_pkg::ST_FULL;
            end else begin
               while (pos < held_count && !(v < held_values[pos])) pos++;
               for (int i = held_count; i > pos; i--) held_values[i] = held_values[i-1];
               held_values[pos] = v;
               held_count++;
            end
         end
         rmed_pkg::CMD_REMOVE: begin
            while (pos < held_count && held_values[pos] != v) pos++;
            if (pos >= held_count) begin
               r.status = rmed_pkg::ST_ABSENT;
            end else begin
               for (int i = pos; i < held_count - 1; i++) held_values[i] = held_values[i+1];
               held_count--;
            end
         end
         rmed_pkg::CMD_CLEAR: begin
            held_count = 0;
         end
         default: ;
      endcase
      r.has_median = (held_count > 0);
      r.count      = rmed_pkg::COUNT_OUT_W'(held_count);
      r.median     = (held_count > 0) ? held_values[(held_count - 1) / 2] : '0;
      return r;
   endfunction

   task automatic flag_mismatch(string what, logic [rmed_pkg::DATA_W-1:0] got,
                                logic [rmed_pkg::DATA_W-1:0] want);
      mismatches++;
      if (mismatches <= PRINT_LIMIT)
         $display("tb: mismatch at cycle %0d: %s got %h want %h", cycle_count, what, got, want);
   endtask

   task automatic send_command(logic [rmed_pkg::CMD_W-1:0] cmd,
                               logic [rmed_pkg::DATA_W-1:0] value,
                               bit typed, median_result_type typed_result);
      median_result_type predicted;
      int gap;
      gap = quiet_sender ? 0 : $urandom_range(0, 18);
      if ($urandom_range(0, 39) == 0) quiet_sender = !quiet_sender;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tuser  <= cmd;
      req_tdata  <= value;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      predicted = apply_command(cmd, value);
      pending_medians.push_back(typed ? typed_result : predicted);
      @(negedge clock);
   endtask

   initial begin : result_sink
      int stall;
      median_result_type got;
      median_result_type want;
      rsp_tready <= 1'b0;
      wait (reset === 1'b0);
      @(negedge clock);
      forever begin
         stall = quiet_receiver ? 0 : $urandom_range(0, 18);
         if ($urandom_range(0, 39) == 0) quiet_receiver = !quiet_receiver;
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (rsp_tvalid !== 1'b1);
         got.median     = rsp_tdata[rmed_pkg::DATA_W-1:0];
         got.has_median = rsp_tdata[rmed_pkg::DATA_W];
         got.count      = rsp_tdata[rmed_pkg::DATA_W+1 +: rmed_pkg::COUNT_OUT_W];
         got.status     = rsp_tuser;
         if (pending_medians.size() == 0) begin
            flag_mismatch("result with nothing pending, median", got.median, '0);
         end else begin
            want = pending_medians.pop_front();
            if (got.median !== want.median)
               flag_mismatch("median", got.median, want.median);
            if (got.has_median !== want.has_median)
               flag_mismatch("has_median", rmed_pkg::DATA_W'(got.has_median),
                             rmed_pkg::DATA_W'(want.has_median));
            if (got.count !== want.count)
               flag_mismatch("element_count", rmed_pkg::DATA_W'(got.count),
                             rmed_pkg::DATA_W'(want.count));
            if (got.status !== want.status)
               flag_mismatch("status", rmed_pkg::DATA_W'(got.status),
                             rmed_pkg::DATA_W'(want.status));
         end
         @(negedge clock);
      end
   end

   initial begin : command_source
      median_result_type           typed_result;
      logic [rmed_pkg::CMD_W-1:0]  cmd;
      logic [rmed_pkg::DATA_W-1:0] value;
      bit                          growing;
      int                          pick;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= rmed_pkg::CMD_ADD;
      held_count = 0;
      growing = 1'b0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         typed_result.median     = directed_rows[i].median;
         typed_result.has_median = directed_rows[i].has_median;
         typed_result.count      = directed_rows[i].count;
         typed_result.status     = directed_rows[i].status;
         send_command(directed_rows[i].cmd, directed_rows[i].value,
                      directed_rows[i].typed, typed_result);
      end

      typed_result = '0;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % PHASE_ITEMS == 0) growing = !growing;
         if (n % DRAIN_EVERY == DRAIN_EVERY - 1) begin
            req_tvalid <= 1'b0;
            @(negedge clock);
            while (pending_medians.size() != 0) @(negedge clock);
         end
         pick = $urandom_range(0, 199);
         if (pick < 1)
            cmd = rmed_pkg::CMD_CLEAR;
         else if (pick < 4)
            cmd = CMD_UNUSED;
         else if (pick < (growing ? 168 : 36))
            cmd = rmed_pkg::CMD_ADD;
         else
            cmd = rmed_pkg::CMD_REMOVE;
         if (cmd == rmed_pkg::CMD_REMOVE && held_count > 0 && $urandom_range(0, 9) < 7) begin
            value = held_values[$urandom_range(0, held_count - 1)];
         end else begin
            pick = $urandom_range(0, 9);
            if (pick < 4) begin
               value = rmed_pkg::DATA_W'($urandom_range(0, 16)) - rmed_pkg::DATA_W'(8);
            end else if (pick < 5) begin
               case ($urandom_range(0, 3))
                  0: value = 32'h8000_0000;
                  1: value = 32'h7FFF_FFFF;
                  2: value = 32'h0000_0000;
                  default: value = 32'hFFFF_FFFF;
               endcase
            end else begin
               value = $urandom;
            end
         end
         send_command(cmd, value, 1'b0, typed_result);
      end

      req_tvalid <= 1'b0;
      while (pending_medians.size() != 0) @(negedge clock);
      repeat (TAIL_CYCLES) @(negedge clock);
      if (mismatches == 0 && pending_medians.size() == 0)
         $display("tb: PASS");
      else
         $display("tb: FAIL");
      $finish;
   end

endmodule
